FILE: rtl/arrt_pkg.sv
// ----------------------------------------------------------------------------
// arrt_pkg
// Shared types and constants for the auto-ranging ratio tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package arrt_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int DIFF_W    = SAMPLE_W + 1;
	localparam int RATIO_W   = 24;
	localparam int QUOT_W    = 32;
	localparam int CNT_W     = 5;
	localparam int CFG_IDX_W = 8;
	localparam int QDEPTH    = 2;

	localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_AUTO   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_AUTO  = 8'd3;

	localparam logic [QUOT_W-1:0] RATIO_POS_LIM = 32'd8388607;
	localparam logic [QUOT_W-1:0] RATIO_NEG_LIM = 32'd8388608;
	localparam logic [RATIO_W-1:0] RATIO_MAX    = 24'h7FFFFF;
	localparam logic [RATIO_W-1:0] RATIO_MIN    = 24'h800000;

	// one request handed from the front to the divider
	typedef struct packed {
		logic                     event_res;
		logic                     ratio_valid;
		logic signed [DIFF_W-1:0] num;
		logic signed [DIFF_W-1:0] den;
		logic signed [SAMPLE_W-1:0] lower;
		logic signed [SAMPLE_W-1:0] upper;
	} job_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} div_state_t;

endpackage

`default_nettype wire

FILE: rtl/arrt_front.sv
// ----------------------------------------------------------------------------
// arrt_front
// Configuration registers, bound tracking and event detection per sample.
// ----------------------------------------------------------------------------
`default_nettype none

module arrt_front import arrt_pkg::*; (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	input  wire logic [CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [SAMPLE_W-1:0]         cfg_data,
	input  wire logic                        accept,
	input  wire logic signed [SAMPLE_W-1:0]  sample,
	output job_t                             job
);

	logic signed [SAMPLE_W-1:0] low_limit_q;
	logic signed [SAMPLE_W-1:0] high_limit_q;
	logic                       low_auto_q;
	logic                       high_auto_q;
	logic                       started_q;
	logic signed [SAMPLE_W-1:0] prev_q;
	logic signed [SAMPLE_W-1:0] low_q;
	logic signed [SAMPLE_W-1:0] high_q;

	logic signed [SAMPLE_W-1:0] lb0, hb0, lb1, hb1, lb2, hb2, prev1;
	logic                       ev1, ev2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_limit_q  <= '0;
			high_limit_q <= '0;
			low_auto_q   <= 1'b1;
			high_auto_q  <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LOW_LIMIT:  low_limit_q  <= cfg_data;
				REG_LOW_AUTO:   low_auto_q   <= cfg_data[0];
				REG_HIGH_LIMIT: high_limit_q <= cfg_data;
				REG_HIGH_AUTO:  high_auto_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		lb0 = low_auto_q  ? low_q  : low_limit_q;
		hb0 = high_auto_q ? high_q : high_limit_q;
		if (!started_q) begin
			prev1 = sample;
			lb1   = low_auto_q  ? sample : lb0;
			hb1   = high_auto_q ? sample : hb0;
			ev1   = !low_auto_q || (!high_auto_q && (lb1 != hb1));
		end else begin
			prev1 = prev_q;
			lb1   = lb0;
			hb1   = hb0;
			ev1   = 1'b0;
		end
		lb2 = lb1;
		hb2 = hb1;
		ev2 = ev1;
		if (sample != prev1) begin
			ev2 = 1'b1;
			// lowering the low bound takes priority over raising the high one
			if (low_auto_q && (sample < lb1))
				lb2 = sample;
			else if (high_auto_q && (sample > hb1))
				hb2 = sample;
		end
		job.event_res   = ev2;
		job.ratio_valid = (hb2 != lb2);
		job.num         = {sample[SAMPLE_W-1], sample} - {lb2[SAMPLE_W-1], lb2};
		job.den         = {hb2[SAMPLE_W-1], hb2} - {lb2[SAMPLE_W-1], lb2};
		job.lower       = lb2;
		job.upper       = hb2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			prev_q    <= '0;
			low_q     <= '0;
			high_q    <= '0;
		end else if (accept) begin
			started_q <= 1'b1;
			prev_q    <= sample;
			low_q     <= lb2;
			high_q    <= hb2;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/arrt_queue.sv
// ----------------------------------------------------------------------------
// arrt_queue
// Two-entry request queue between the front and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module arrt_queue import arrt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	output logic      full,
	input  wire logic pop,
	output logic      head_valid,
	output job_t      head_job
);

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CW    = $clog2(QDEPTH + 1);

	job_t             entry_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full       = (count_q == CW'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QDEPTH))
		else $error("queue count above depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

endmodule

`default_nettype wire

FILE: rtl/arrt_div.sv
// ----------------------------------------------------------------------------
// arrt_div
// Radix-2 restoring divider with saturation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module arrt_div import arrt_pkg::*; (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        head_valid,
	input  wire job_t                        head_job,
	output logic                             pop,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             event_res,
	output logic signed [RATIO_W-1:0]        ratio,
	output logic                             ratio_valid,
	output logic signed [SAMPLE_W-1:0]       lower_bound,
	output logic signed [SAMPLE_W-1:0]       upper_bound
);

	div_state_t state_q, state_d;

	logic [DIFF_W-1:0]   rem_q;
	logic [QUOT_W-1:0]   dvd_q;
	logic [SAMPLE_W-1:0] dsr_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                neg_q;
	logic                ev_q, vld_q;
	logic [SAMPLE_W-1:0] lo_q, hi_q;

	logic                out_valid_q;
	logic                out_ev_q, out_vld_q;
	logic [RATIO_W-1:0]  out_ratio_q;
	logic [SAMPLE_W-1:0] out_lo_q, out_hi_q;

	logic [DIFF_W-1:0]   num_mag, den_mag;
	logic [DIFF_W-1:0]   rem_sh;
	logic                ge;
	logic                out_free;
	logic                load_out;
	logic [RATIO_W-1:0]  sat;

	assign num_mag  = head_job.num[DIFF_W-1] ? -head_job.num : head_job.num;
	assign den_mag  = head_job.den[DIFF_W-1] ? -head_job.den : head_job.den;
	assign rem_sh   = {rem_q[DIFF_W-2:0], dvd_q[QUOT_W-1]};
	assign ge       = rem_sh >= {1'b0, dsr_q};
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (head_valid) begin
					pop     = 1'b1;
					// equal bounds skip the divide, ratio reads zero
					state_d = head_job.ratio_valid ? ST_DIV : ST_DONE;
				end
			end
			ST_DIV: begin
				if (cnt_q == '1)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// quotient magnitude in dvd_q, clamp to the q8.16 range
	always_comb begin
		if (!vld_q)
			sat = '0;
		else if (!neg_q)
			sat = (dvd_q > RATIO_POS_LIM) ? RATIO_MAX : dvd_q[RATIO_W-1:0];
		else
			sat = (dvd_q > RATIO_NEG_LIM) ? RATIO_MIN : -dvd_q[RATIO_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rem_q <= '0;
			dvd_q <= {num_mag[SAMPLE_W-1:0], {SAMPLE_W{1'b0}}};
			dsr_q <= den_mag[SAMPLE_W-1:0];
			cnt_q <= '0;
			neg_q <= head_job.num[DIFF_W-1] ^ head_job.den[DIFF_W-1];
			ev_q  <= head_job.event_res;
			vld_q <= head_job.ratio_valid;
			lo_q  <= head_job.lower;
			hi_q  <= head_job.upper;
		end else if (state_q == ST_DIV) begin
			rem_q <= ge ? rem_sh - {1'b0, dsr_q} : rem_sh;
			dvd_q <= {dvd_q[QUOT_W-2:0], ge};
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_ev_q    <= ev_q;
			out_vld_q   <= vld_q;
			out_ratio_q <= sat;
			out_lo_q    <= lo_q;
			out_hi_q    <= hi_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign event_res   = out_ev_q;
	assign ratio       = out_ratio_q;
	assign ratio_valid = out_vld_q;
	assign lower_bound = out_lo_q;
	assign upper_bound = out_hi_q;

	a_rem_below_dsr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < {1'b0, dsr_q}))
		else $error("divider remainder not below divisor");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == ST_IDLE))
		else $error("queue popped while divider busy");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && state_d == ST_DONE) |-> (cnt_q == '1))
		else $error("divide ended early");

endmodule

`default_nettype wire

FILE: rtl/auto_ranging_ratio_tracker.sv
// the divider works on one sample at a time: it loads a request from the queue,
// runs the 32 steps of the radix-2 divider and retires the result into the output
// register, waiting there while the output stalls; equal bounds skip the divide
// the front takes up to two samples ahead while the divider works
// reset: asynchronous active low, bounds and previous sample clear to zero,
// both auto bits set, limits zero, queue and output empty
// ----------------------------------------------------------------------------
// auto_ranging_ratio_tracker
// Min/max normalizer: tracks bounds and returns (sample-low)/(high-low) q8.16.
// ----------------------------------------------------------------------------
`default_nettype none

module auto_ranging_ratio_tracker import arrt_pkg::*; (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [SAMPLE_W-1:0]         cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic signed [SAMPLE_W-1:0]  sample,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             event_res,
	output logic signed [RATIO_W-1:0]        ratio,
	output logic                             ratio_valid,
	output logic signed [SAMPLE_W-1:0]       lower_bound,
	output logic signed [SAMPLE_W-1:0]       upper_bound
);

	logic accept;
	logic full;
	logic pop;
	logic head_valid;
	job_t job;
	job_t head_job;

	assign cfg_ready = 1'b1;
	assign in_stall  = full;
	assign accept    = in_valid && !full;

	arrt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.sample    (sample),
		.job       (job)
	);

	arrt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_job   (job),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	arrt_div u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_job    (head_job),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.event_res   (event_res),
		.ratio       (ratio),
		.ratio_valid (ratio_valid),
		.lower_bound (lower_bound),
		.upper_bound (upper_bound)
	);

endmodule

`default_nettype wire

FILE: tb/sv/arrt_result_checker.sv
// ----------------------------------------------------------------------------
// arrt_result_checker
// Watches the sample, result and register channels of the ratio tracker,
// tracks the bounds the same way the block should and compares every result.
// ----------------------------------------------------------------------------
module arrt_result_checker import arrt_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [SAMPLE_W-1:0]         cfg_data,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic signed [SAMPLE_W-1:0]  sample,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic                        event_res,
	input  logic signed [RATIO_W-1:0]   ratio,
	input  logic                        ratio_valid,
	input  logic signed [SAMPLE_W-1:0]  lower_bound,
	input  logic signed [SAMPLE_W-1:0]  upper_bound,
	output int                          mismatches,
	output int                          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                       event_res;
		logic signed [RATIO_W-1:0]  ratio;
		logic                       ratio_valid;
		logic signed [SAMPLE_W-1:0] lower;
		logic signed [SAMPLE_W-1:0] upper;
	} ratio_result_t;

	localparam longint Q_MAX = 64'sd8388607;
	localparam longint Q_MIN = -64'sd8388608;

	logic signed [SAMPLE_W-1:0] low_limit_reg;
	logic signed [SAMPLE_W-1:0] high_limit_reg;
	logic                       low_auto_reg;
	logic                       high_auto_reg;
	logic                       seen_first;
	logic signed [SAMPLE_W-1:0] last_sample;
	logic signed [SAMPLE_W-1:0] low_bd;
	logic signed [SAMPLE_W-1:0] high_bd;
	ratio_result_t              pending_ratios[$];
	ratio_result_t              want;
	ratio_result_t              got;

	// updates the tracked bounds and returns what the block should report
	function automatic ratio_result_t track_sample(input logic signed [SAMPLE_W-1:0] s);
		ratio_result_t r;
		longint num;
		longint den;
		longint q;
		r = '0;
		if (!low_auto_reg)
			low_bd = low_limit_reg;
		if (!high_auto_reg)
			high_bd = high_limit_reg;
		if (!seen_first) begin
			seen_first = 1'b1;
			last_sample = s;
			if (low_auto_reg)
				low_bd = s;
			if (high_auto_reg)
				high_bd = s;
			// or binds looser than and: fixed low alone is enough
			if (!low_auto_reg || (!high_auto_reg && low_bd != high_bd))
				r.event_res = 1'b1;
		end
		if (s != last_sample) begin
			// a lowered bound blocks raising the other on the same sample
			if (low_auto_reg && s < low_bd)
				low_bd = s;
			else if (high_auto_reg && s > high_bd)
				high_bd = s;
			r.event_res = 1'b1;
		end
		last_sample = s;
		if (high_bd != low_bd) begin
			num = (longint'(s) - longint'(low_bd)) * 65536;
			den = longint'(high_bd) - longint'(low_bd);
			q = num / den;
			if (q > Q_MAX)
				q = Q_MAX;
			if (q < Q_MIN)
				q = Q_MIN;
			r.ratio = q[RATIO_W-1:0];
			r.ratio_valid = 1'b1;
		end
		r.lower = low_bd;
		r.upper = high_bd;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_limit_reg = '0;
			high_limit_reg = '0;
			low_auto_reg = 1'b1;
			high_auto_reg = 1'b1;
			seen_first = 1'b0;
			last_sample = '0;
			low_bd = '0;
			high_bd = '0;
			pending_ratios.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			// results first, so a result can never match a request of the same edge
			if (out_valid && !out_stall) begin
				got.event_res = event_res;
				got.ratio = ratio;
				got.ratio_valid = ratio_valid;
				got.lower = lower_bound;
				got.upper = upper_bound;
				if (pending_ratios.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with none pending: ev=%0d ratio=%0d ok=%0d lo=%0d hi=%0d",
							$realtime, got.event_res, got.ratio, got.ratio_valid,
							got.lower, got.upper);
				end else begin
					want = pending_ratios.pop_front();
					if (got.event_res !== want.event_res || got.ratio !== want.ratio ||
						got.ratio_valid !== want.ratio_valid || got.lower !== want.lower ||
						got.upper !== want.upper) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: expected ev=%0d ratio=%0d ok=%0d lo=%0d hi=%0d",
								$realtime, want.event_res, want.ratio, want.ratio_valid,
								want.lower, want.upper);
							$display("%0t: actual   ev=%0d ratio=%0d ok=%0d lo=%0d hi=%0d",
								$realtime, got.event_res, got.ratio, got.ratio_valid,
								got.lower, got.upper);
						end
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LOW_LIMIT:  low_limit_reg = cfg_data;
					REG_LOW_AUTO:   low_auto_reg = cfg_data[0];
					REG_HIGH_LIMIT: high_limit_reg = cfg_data;
					REG_HIGH_AUTO:  high_auto_reg = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				pending_ratios.push_back(track_sample(sample));
			outstanding = pending_ratios.size();
		end
	end

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives samples and register writes into the ratio tracker with random gaps
// and output stalls, including a long hold-off; the checker scores results.
// ----------------------------------------------------------------------------
module testbench;
	import arrt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT   = 3000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASES        = 13;
	localparam int PHASE_SAMPLES = 98;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index = REG_LOW_LIMIT;
	logic [SAMPLE_W-1:0]        cfg_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic                       event_res;
	logic signed [RATIO_W-1:0]  ratio;
	logic                       ratio_valid;
	logic signed [SAMPLE_W-1:0] lower_bound;
	logic signed [SAMPLE_W-1:0] upper_bound;

	int                         mismatches;
	int                         outstanding;
	int                         send_idle_pct = 35;
	int                         recv_stall_pct = 35;
	int                         holds_asked = 0;
	int                         holds_granted = 0;
	int                         hold_left = 0;
	int                         quiet_cycles = 0;
	logic signed [SAMPLE_W-1:0] last_sent = '0;

	auto_ranging_ratio_tracker dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .sample(sample),
		.out_valid(out_valid), .out_stall(out_stall),
		.event_res(event_res), .ratio(ratio), .ratio_valid(ratio_valid),
		.lower_bound(lower_bound), .upper_bound(upper_bound)
	);

	arrt_result_checker results_chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .sample(sample),
		.out_valid(out_valid), .out_stall(out_stall),
		.event_res(event_res), .ratio(ratio), .ratio_valid(ratio_valid),
		.lower_bound(lower_bound), .upper_bound(upper_bound),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random stalls, plus a long hold-off when one is asked for
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else if (holds_granted != holds_asked) begin
			holds_granted = holds_granted + 1;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[auto_ranging_ratio_tracker] ERROR");
				$finish;
			end
		end
	end

	// all tasks start and end at a falling edge
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= value;
		last_sent = value;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic set_config(input logic [SAMPLE_W-1:0] lo_lim, input logic [SAMPLE_W-1:0] lo_auto,
		input logic [SAMPLE_W-1:0] hi_lim, input logic [SAMPLE_W-1:0] hi_auto);
		put_reg(REG_LOW_LIMIT, lo_lim);
		put_reg(REG_LOW_AUTO, lo_auto);
		put_reg(REG_HIGH_LIMIT, hi_lim);
		put_reg(REG_HIGH_AUTO, hi_auto);
		cfg_valid <= 1'b0;
	endtask

	// stop offering and wait until every result is back
	task automatic drain();
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		int r;
		int v;
		r = $urandom_range(99);
		if (r < 25)
			return last_sent;
		if (r < 40) begin
			case ($urandom_range(5))
				0: return 16'sh8000;
				1: return 16'sh7FFF;
				2: return 16'sh8001;
				3: return 16'sh7FFE;
				4: return 16'sh0000;
				default: return 16'shFFFF;
			endcase
		end
		if (r < 70) begin
			v = $urandom_range(255) - 128;
			return v[SAMPLE_W-1:0];
		end
		return SAMPLE_W'($urandom);
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_limit();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return SAMPLE_W'($urandom_range(255) - 128);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	initial begin
		logic [SAMPLE_W-1:0] lo_lim;
		logic [SAMPLE_W-1:0] hi_lim;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// first sample with a fixed high bound that differs from the learned low
		set_config(16'd0, 16'd1, 16'd100, 16'd0);
		send_sample(-16'sd5);
		send_sample(-16'sd5);
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(16'sd0);
		send_sample(16'sd0);
		drain();

		// full-scale fixed bounds
		set_config(16'h8000, 16'd0, 16'h7FFF, 16'd0);
		send_sample(16'sh8000);
		send_sample(16'sh7FFF);
		send_sample(16'sd0);
		send_sample(16'sd1);
		send_sample(-16'sd1);
		drain();

		// inverted fixed bounds, negative divisor
		set_config(16'd1000, 16'd0, -16'sd1000, 16'd0);
		send_sample(16'sd0);
		send_sample(16'sd1000);
		send_sample(-16'sd1000);
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		drain();

		// equal bounds
		set_config(16'd7, 16'd0, 16'd7, 16'd0);
		send_sample(16'sd7);
		send_sample(16'sd8);
		send_sample(16'sh8000);
		drain();

		// learning resumes from the bounds held under the previous fixed values
		set_config(16'h7FFF, 16'hFFFF, 16'h8000, 16'h0001);
		send_sample(16'sd20);
		send_sample(16'sd3);
		send_sample(16'sd3);
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			send_idle_pct = (ph == 2) ? 0 : 35;
			recv_stall_pct = (ph == 2) ? 0 : 35;
			lo_lim = pick_limit();
			hi_lim = ($urandom_range(9) == 0) ? lo_lim : pick_limit();
			set_config(lo_lim, {15'($urandom), 1'($urandom_range(1))},
				hi_lim, {15'($urandom), 1'($urandom_range(1))});
			if (ph == 5) begin
				// back-to-back requests against a held-off output
				send_idle_pct = 0;
				holds_asked <= holds_asked + 1;
				for (int i = 0; i < 12; i++)
					send_sample(pick_sample());
				send_idle_pct = 35;
			end
			for (int i = 0; i < PHASE_SAMPLES; i++)
				send_sample(pick_sample());
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("[auto_ranging_ratio_tracker] OK");
		else
			$display("[auto_ranging_ratio_tracker] ERROR");
		$finish;
	end

endmodule
